FILE: hdl/hextile_pkg.sv
package hextile_pkg;

    localparam int TILE_SIDE = 16;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 96;

    // subencoding flag bits
    localparam int SE_RAW       = 0;
    localparam int SE_BG        = 1;
    localparam int SE_FG        = 2;
    localparam int SE_ANY_SUB   = 3;
    localparam int SE_SUB_COLOR = 4;
    localparam int SE_ZLIB_RAW  = 5;
    localparam int SE_ZLIB_HEX  = 6;

    localparam logic REQ_HEADER = 1'b0;
    localparam logic KIND_FILL  = 1'b0;
    localparam logic KIND_ZLIB  = 1'b1;

    localparam logic [1:0] PIX_CODE_1B = 2'd0;
    localparam logic [1:0] PIX_CODE_2B = 2'd1;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_SUBENC    = 12'b0000_0000_0010,
        PH_RAW       = 12'b0000_0000_0100,
        PH_LEN_HI    = 12'b0000_0000_1000,
        PH_LEN_LO    = 12'b0000_0001_0000,
        PH_SKIP      = 12'b0000_0010_0000,
        PH_BG        = 12'b0000_0100_0000,
        PH_FG        = 12'b0000_1000_0000,
        PH_NSUB      = 12'b0001_0000_0000,
        PH_SUB_COLOR = 12'b0010_0000_0000,
        PH_SUB_XY    = 12'b0100_0000_0000,
        PH_SUB_WH    = 12'b1000_0000_0000
    } phase_t;

endpackage

FILE: hdl/hextile_tile_stream_decoder_top.sv
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tuser: req_type; tdata: byte, x, y, w, h
// m_*       out  m_tvalid / m_tready     tuser: out_kind; tdata: fill or tile command
// cfg_*     in   cfg_valid / cfg_ready   pixel_size_code
//
// one word per cycle sustained while m_* is not stalled; a word goes input register -> parse ->
// output register, and each result is presented on m_* from the output register
// a word that gives no result leaves the output payload untouched
// while the output register is stalled the input register holds one more word
// rst_n clears parse state, colors and pixel size code; cfg_ready is always high
module hextile_tile_stream_decoder_top
    import hextile_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte, rect_x, rect_y, rect_w, rect_h
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_x, out_y, out_w, out_h, out_color, out_length
    output logic                  m_tuser,   // out_kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_data   // pixel_size_code
);

    localparam logic [16:0] SIDE17 = 17'(TILE_SIDE);

    function automatic logic [4:0] clip_side(input logic [16:0] rem);
        if (rem < SIDE17)
        begin
            clip_side = rem[4:0];
        end
        else
        begin
            clip_side = 5'(TILE_SIDE);
        end
    endfunction

    // input register
    logic                 in_valid_reg;
    logic                 in_req_reg;
    logic [IN_DATA_W-1:0] in_data_reg;

    // output register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [4:0]  out_w_reg;
    logic [4:0]  out_h_reg;
    logic [31:0] out_color_reg;
    logic [15:0] out_length_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [1:0]  pix_code_reg;
    logic [15:0] org_x_reg, org_x_next;
    logic [15:0] org_y_reg, org_y_next;
    logic [15:0] size_w_reg, size_w_next;
    logic [15:0] size_h_reg, size_h_next;
    logic [16:0] tile_dx_reg, tile_dx_next;
    logic [16:0] tile_dy_reg, tile_dy_next;
    logic [4:0]  tile_w_reg, tile_w_next;
    logic [4:0]  tile_h_reg, tile_h_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] pix_acc_reg, pix_acc_next;
    logic [1:0]  pix_cnt_reg, pix_cnt_next;
    logic [31:0] bg_reg, bg_next;
    logic [31:0] fg_reg, fg_next;
    logic [7:0]  nsub_reg, nsub_next;
    logic [7:0]  subpos_reg, subpos_next;
    logic [3:0]  raw_col_reg, raw_col_next;
    logic [3:0]  raw_row_reg, raw_row_next;
    logic [15:0] skip_reg, skip_next;

    logic advance;
    logic emit;
    logic emit_kind;
    logic [15:0] emit_x, emit_y, emit_length;
    logic [4:0]  emit_w, emit_h;
    logic [31:0] emit_color;
    logic go_next_tile;

    logic [7:0]  in_byte;
    logic [15:0] hdr_x, hdr_y, hdr_w, hdr_h;
    logic [15:0] tile_x, tile_y;

    logic [31:0] pix_merged;
    logic [2:0]  pix_cnt_inc;
    logic [2:0]  pix_bytes;
    logic        pix_done;

    logic [16:0] dx_step, dy_step;
    logic        dx_wrap;
    logic [16:0] nt_dx, nt_dy;
    logic        nt_done;

    logic [4:0]  col_inc, row_inc;
    logic [15:0] len_full;
    logic [15:0] skip_dec;
    logic [7:0]  nsub_dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'b0, out_length_reg, out_color_reg, out_h_reg, out_w_reg,
                       out_y_reg, out_x_reg};

    assign in_byte = in_data_reg[7:0];
    assign hdr_x   = in_data_reg[23:8];
    assign hdr_y   = in_data_reg[39:24];
    assign hdr_w   = in_data_reg[55:40];
    assign hdr_h   = in_data_reg[71:56];

    assign tile_x = org_x_reg + tile_dx_reg[15:0];
    assign tile_y = org_y_reg + tile_dy_reg[15:0];

    // pixel assembly, little-endian
    assign pix_merged  = pix_acc_reg | ({24'b0, in_byte} << {pix_cnt_reg, 3'b000});
    assign pix_cnt_inc = {1'b0, pix_cnt_reg} + 3'd1;
    always_comb
    begin
        unique case (pix_code_reg)
            PIX_CODE_1B: pix_bytes = 3'd1;
            PIX_CODE_2B: pix_bytes = 3'd2;
            default:     pix_bytes = 3'd4;
        endcase
    end
    assign pix_done = pix_cnt_inc >= pix_bytes;

    // next tile position
    assign dx_step = tile_dx_reg + SIDE17;
    assign dy_step = tile_dy_reg + SIDE17;
    assign dx_wrap = dx_step >= {1'b0, size_w_reg};
    assign nt_dx   = dx_wrap ? 17'd0 : dx_step;
    assign nt_dy   = dx_wrap ? dy_step : tile_dy_reg;
    assign nt_done = dx_wrap && (dy_step >= {1'b0, size_h_reg});

    assign col_inc  = {1'b0, raw_col_reg} + 5'd1;
    assign row_inc  = {1'b0, raw_row_reg} + 5'd1;
    assign len_full = skip_reg | {8'b0, in_byte};
    assign skip_dec = skip_reg - 16'd1;
    assign nsub_dec = nsub_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        org_x_next   = org_x_reg;
        org_y_next   = org_y_reg;
        size_w_next  = size_w_reg;
        size_h_next  = size_h_reg;
        tile_dx_next = tile_dx_reg;
        tile_dy_next = tile_dy_reg;
        tile_w_next  = tile_w_reg;
        tile_h_next  = tile_h_reg;
        flags_next   = flags_reg;
        pix_acc_next = pix_acc_reg;
        pix_cnt_next = pix_cnt_reg;
        bg_next      = bg_reg;
        fg_next      = fg_reg;
        nsub_next    = nsub_reg;
        subpos_next  = subpos_reg;
        raw_col_next = raw_col_reg;
        raw_row_next = raw_row_reg;
        skip_next    = skip_reg;
        go_next_tile = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_FILL;
        emit_x       = tile_x;
        emit_y       = tile_y;
        emit_w       = tile_w_reg;
        emit_h       = tile_h_reg;
        emit_color   = bg_reg;
        emit_length  = 16'd0;

        if (advance)
        begin
            if (in_req_reg == REQ_HEADER)
            begin
                org_x_next   = hdr_x;
                org_y_next   = hdr_y;
                size_w_next  = hdr_w;
                size_h_next  = hdr_h;
                tile_dx_next = 17'd0;
                tile_dy_next = 17'd0;
                pix_acc_next = 32'd0;
                pix_cnt_next = 2'd0;
                tile_w_next  = clip_side({1'b0, hdr_w});
                tile_h_next  = clip_side({1'b0, hdr_h});
                if (hdr_w == 16'd0 || hdr_h == 16'd0)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_SUBENC;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SUBENC:
                    begin
                        flags_next   = in_byte;
                        pix_acc_next = 32'd0;
                        pix_cnt_next = 2'd0;
                        priority if (in_byte[SE_RAW])
                        begin
                            raw_col_next = 4'd0;
                            raw_row_next = 4'd0;
                            phase_next   = PH_RAW;
                        end
                        else if (in_byte[SE_ZLIB_RAW] || in_byte[SE_ZLIB_HEX])
                        begin
                            phase_next = PH_LEN_HI;
                        end
                        else if (in_byte[SE_BG])
                        begin
                            phase_next = PH_BG;
                        end
                        else
                        begin
                            emit = 1'b1;
                            priority if (in_byte[SE_FG])
                            begin
                                phase_next = PH_FG;
                            end
                            else if (in_byte[SE_ANY_SUB])
                            begin
                                phase_next = PH_NSUB;
                            end
                            else
                            begin
                                go_next_tile = 1'b1;
                            end
                        end
                    end
                    PH_RAW:
                    begin
                        if (pix_done)
                        begin
                            pix_acc_next = 32'd0;
                            pix_cnt_next = 2'd0;
                            emit       = 1'b1;
                            emit_x     = tile_x + {12'b0, raw_col_reg};
                            emit_y     = tile_y + {12'b0, raw_row_reg};
                            emit_w     = 5'd1;
                            emit_h     = 5'd1;
                            emit_color = pix_merged;
                            if (col_inc >= tile_w_reg)
                            begin
                                raw_col_next = 4'd0;
                                raw_row_next = row_inc[3:0];
                                if (row_inc >= tile_h_reg)
                                begin
                                    go_next_tile = 1'b1;
                                end
                            end
                            else
                            begin
                                raw_col_next = col_inc[3:0];
                            end
                        end
                        else
                        begin
                            pix_acc_next = pix_merged;
                            pix_cnt_next = pix_cnt_inc[1:0];
                        end
                    end
                    PH_LEN_HI:
                    begin
                        skip_next  = {in_byte, 8'b0};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        skip_next   = len_full;
                        emit        = 1'b1;
                        emit_kind   = KIND_ZLIB;
                        emit_color  = 32'd0;
                        emit_length = len_full;
                        if (len_full == 16'd0)
                        begin
                            go_next_tile = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0)
                        begin
                            go_next_tile = 1'b1;
                        end
                    end
                    PH_BG:
                    begin
                        if (pix_done)
                        begin
                            pix_acc_next = 32'd0;
                            pix_cnt_next = 2'd0;
                            bg_next      = pix_merged;
                            emit         = 1'b1;
                            emit_color   = pix_merged;
                            priority if (flags_reg[SE_FG])
                            begin
                                phase_next = PH_FG;
                            end
                            else if (flags_reg[SE_ANY_SUB])
                            begin
                                phase_next = PH_NSUB;
                            end
                            else
                            begin
                                go_next_tile = 1'b1;
                            end
                        end
                        else
                        begin
                            pix_acc_next = pix_merged;
                            pix_cnt_next = pix_cnt_inc[1:0];
                        end
                    end
                    PH_FG:
                    begin
                        if (pix_done)
                        begin
                            pix_acc_next = 32'd0;
                            pix_cnt_next = 2'd0;
                            fg_next      = pix_merged;
                            if (flags_reg[SE_ANY_SUB])
                            begin
                                phase_next = PH_NSUB;
                            end
                            else
                            begin
                                go_next_tile = 1'b1;
                            end
                        end
                        else
                        begin
                            pix_acc_next = pix_merged;
                            pix_cnt_next = pix_cnt_inc[1:0];
                        end
                    end
                    PH_NSUB:
                    begin
                        nsub_next = in_byte;
                        if (in_byte == 8'd0)
                        begin
                            go_next_tile = 1'b1;
                        end
                        else
                        begin
                            phase_next = flags_reg[SE_SUB_COLOR] ? PH_SUB_COLOR : PH_SUB_XY;
                        end
                    end
                    PH_SUB_COLOR:
                    begin
                        if (pix_done)
                        begin
                            pix_acc_next = 32'd0;
                            pix_cnt_next = 2'd0;
                            fg_next      = pix_merged;
                            phase_next   = PH_SUB_XY;
                        end
                        else
                        begin
                            pix_acc_next = pix_merged;
                            pix_cnt_next = pix_cnt_inc[1:0];
                        end
                    end
                    PH_SUB_XY:
                    begin
                        subpos_next = in_byte;
                        phase_next  = PH_SUB_WH;
                    end
                    PH_SUB_WH:
                    begin
                        emit       = 1'b1;
                        emit_x     = tile_x + {12'b0, subpos_reg[7:4]};
                        emit_y     = tile_y + {12'b0, subpos_reg[3:0]};
                        emit_w     = {1'b0, in_byte[7:4]} + 5'd1;
                        emit_h     = {1'b0, in_byte[3:0]} + 5'd1;
                        emit_color = fg_reg;
                        nsub_next  = nsub_dec;
                        if (nsub_dec == 8'd0)
                        begin
                            go_next_tile = 1'b1;
                        end
                        else
                        begin
                            phase_next = flags_reg[SE_SUB_COLOR] ? PH_SUB_COLOR : PH_SUB_XY;
                        end
                    end
                    default:
                    begin
                        // idle: data words are dropped
                    end
                endcase

                if (go_next_tile)
                begin
                    tile_dx_next = nt_dx;
                    tile_dy_next = nt_dy;
                    tile_w_next  = clip_side({1'b0, size_w_reg} - nt_dx);
                    tile_h_next  = clip_side({1'b0, size_h_reg} - nt_dy);
                    phase_next   = nt_done ? PH_IDLE : PH_SUBENC;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pix_code_reg  <= PIX_CODE_1B;
            phase_reg     <= PH_IDLE;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            size_w_reg    <= '0;
            size_h_reg    <= '0;
            tile_dx_reg   <= '0;
            tile_dy_reg   <= '0;
            tile_w_reg    <= '0;
            tile_h_reg    <= '0;
            flags_reg     <= '0;
            pix_acc_reg   <= '0;
            pix_cnt_reg   <= '0;
            bg_reg        <= '0;
            fg_reg        <= '0;
            nsub_reg      <= '0;
            subpos_reg    <= '0;
            raw_col_reg   <= '0;
            raw_row_reg   <= '0;
            skip_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= emit || (out_valid_reg && !m_tready);
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                pix_code_reg <= cfg_data;
            end
            phase_reg   <= phase_next;
            org_x_reg   <= org_x_next;
            org_y_reg   <= org_y_next;
            size_w_reg  <= size_w_next;
            size_h_reg  <= size_h_next;
            tile_dx_reg <= tile_dx_next;
            tile_dy_reg <= tile_dy_next;
            tile_w_reg  <= tile_w_next;
            tile_h_reg  <= tile_h_next;
            flags_reg   <= flags_next;
            pix_acc_reg <= pix_acc_next;
            pix_cnt_reg <= pix_cnt_next;
            bg_reg      <= bg_next;
            fg_reg      <= fg_next;
            nsub_reg    <= nsub_next;
            subpos_reg  <= subpos_next;
            raw_col_reg <= raw_col_next;
            raw_row_reg <= raw_row_next;
            skip_reg    <= skip_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance && emit)
        begin
            out_kind_reg   <= emit_kind;
            out_x_reg      <= emit_x;
            out_y_reg      <= emit_y;
            out_w_reg      <= emit_w;
            out_h_reg      <= emit_h;
            out_color_reg  <= emit_color;
            out_length_reg <= emit_length;
        end
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_w_reg != 5'd0 && out_h_reg != 5'd0)
        else $error("result with zero size");

    a_zlib_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ZLIB |-> out_color_reg == 32'd0)
        else $error("skipped tile carries a color");

    a_header_opens: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_req_reg == REQ_HEADER && hdr_w != 16'd0 && hdr_h != 16'd0
        |=> phase_reg == PH_SUBENC && tile_w_reg != 5'd0 && tile_h_reg != 5'd0)
        else $error("header did not open a tile");

endmodule
